/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the matcher's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NFA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NFA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/nfa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_pkg
// Types, codes and constants shared by the NFA string matcher files.
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int NUM_STATES_DEF = 32;
  localparam int MAX_TRANS_DEF  = 4;

  localparam int SLOT_W  = 7;
  localparam int STATE_W = 5;
  localparam int CHAR_W  = 8;
  // Stored edge: is_char, char, target. The valid bit lives in flip-flops.
  localparam int EDGE_W  = 1 + CHAR_W + STATE_W;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CHAR  = 2'd1;
  localparam logic [1:0] REQ_EMPTY = 2'd2;

  localparam logic CFG_START  = 1'b0;
  localparam logic CFG_ACCEPT = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLOT_W-1:0]  slot_index;
    logic               slot_valid;
    logic               slot_is_char;
    logic [CHAR_W-1:0]  slot_char;
    logic [STATE_W-1:0] slot_target;
    logic [CHAR_W-1:0]  char_value;
    logic               first;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic died_early;
  } out_item_t;

  typedef struct packed {
    logic               addr;
    logic [STATE_W-1:0] wdata;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_CLOSE,
    ST_RESP
  } state_e;

endpackage

/* src/nfa_stream_if.sv */
// ----------------------------------------------------------------------------
// nfa_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface nfa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/nfa_string_matcher.sv */
// ----------------------------------------------------------------------------
// nfa_string_matcher
// Whole-string matcher that simulates an NFA over a loaded edge table.
// ----------------------------------------------------------------------------
// Channels: in_i takes requests (table slot write, string byte, empty-string
// query), out_o returns one result per string end or query, and cfg_i writes
// the start and accept state registers; the user must write them only while
// the block is idle, which the block itself does not enforce. Requests are
// accepted in the idle state. A table write or an unused request completes
// there, so another one can follow in the next cycle. A string byte or a
// query is processed by one scanner that walks the edge table one state row
// per cycle, all MAX_TRANS slots of that row in parallel. A byte costs one
// character pass plus its epsilon closure passes; a closure repeats its pass
// until one adds no state, so it needs at most NUM_STATES passes. A byte that
// matches no edge ends after its character pass, a byte of a dead string
// takes no pass, and a first byte adds the closure of the start state ahead
// of the character pass. in_i is not ready while a request is in work or a
// result waits; a stalled receiver only delays the return to idle. Reset
// clears all table slots to invalid, empties the active set and sets start
// state 0, accept state 1.
// ----------------------------------------------------------------------------
module nfa_string_matcher #(
  parameter int NUM_STATES = nfa_pkg::NUM_STATES_DEF,
  parameter int MAX_TRANS  = nfa_pkg::MAX_TRANS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nfa_stream_if.sink   in_i,
  nfa_stream_if.source out_o,
  nfa_stream_if.sink   cfg_i
);

  localparam int TblSlots   = NUM_STATES * MAX_TRANS;
  localparam int TblDepth   = (TblSlots < (1 << nfa_pkg::SLOT_W)) ? TblSlots
                                                                  : (1 << nfa_pkg::SLOT_W);
  localparam int IdxW       = $clog2(TblDepth);
  localparam int RowW       = $clog2(NUM_STATES);
  localparam int CntW       = $clog2(NUM_STATES + 1);
  localparam int BaseW      = $clog2(TblSlots + MAX_TRANS);
  localparam int ColW       = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int RecipShift = nfa_pkg::SLOT_W + 3;
  localparam int Recip      = ((1 << RecipShift) + MAX_TRANS - 1) / MAX_TRANS;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = nfa_pkg::SLOT_W + RecipW;

  nfa_pkg::in_item_t  in_item;
  nfa_pkg::cfg_item_t cfg_item;
  nfa_pkg::out_item_t res;

  nfa_pkg::state_e st_q, st_d;

  logic [NUM_STATES-1:0]      work_q, work_d;
  logic [NUM_STATES-1:0]      nxt_q, nxt_d;
  logic [NUM_STATES-1:0]      active_q, active_d;
  logic                       dead_q, dead_d;
  logic                       chg_q, chg_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [nfa_pkg::CHAR_W-1:0] char_q, char_d;
  logic                       last_q, last_d;
  logic                       query_q, query_d;
  logic [nfa_pkg::STATE_W-1:0] start_q, start_d;
  logic [nfa_pkg::STATE_W-1:0] acc_q, acc_d;
  logic [TblDepth-1:0]        vld_q, vld_d;

  logic in_fire, cfg_fire, out_fire;
  logic in_pass, pass_end, row_live;

  assign in_item  = in_i.data;
  assign cfg_item = cfg_i.data;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign in_pass  = (st_q == nfa_pkg::ST_START) || (st_q == nfa_pkg::ST_STEP) ||
                    (st_q == nfa_pkg::ST_CLOSE);
  assign pass_end = in_pass && (cnt_q == CntW'(NUM_STATES));
  assign row_live = in_pass && (cnt_q != '0);

  // --------------------------------------------------------------------------
  // Table write decode: row = slot / MAX_TRANS by reciprocal multiply, which
  // is exact for every 7-bit slot index.
  // --------------------------------------------------------------------------
  logic [ProdW-1:0]           wr_prod;
  logic [nfa_pkg::SLOT_W:0]   wr_row_full;
  logic [RowW-1:0]            wr_row;
  logic [nfa_pkg::SLOT_W-1:0] wr_col_full;
  logic [ColW-1:0]            wr_col;
  logic                       wr_ok;
  logic                       wr_en;

  assign wr_prod     = ProdW'(in_item.slot_index) * ProdW'(Recip);
  assign wr_row_full = wr_prod[ProdW-1:RecipShift];
  assign wr_row      = wr_row_full[RowW-1:0];
  assign wr_col_full = in_item.slot_index -
                       nfa_pkg::SLOT_W'(int'(wr_row_full) * MAX_TRANS);
  assign wr_col      = wr_col_full[ColW-1:0];
  assign wr_ok       = int'(in_item.slot_index) < TblSlots;
  assign wr_en       = in_fire && (in_item.req_type == nfa_pkg::REQ_WRITE) && wr_ok;

  // --------------------------------------------------------------------------
  // Edge storage: one RAM per slot column, rows indexed by source state.
  // --------------------------------------------------------------------------
  logic [nfa_pkg::EDGE_W-1:0] rdata [MAX_TRANS];
  logic [RowW-1:0]            raddr;

  assign raddr = cnt_q[RowW-1:0];

  for (genvar k = 0; k < MAX_TRANS; k++) begin : g_col
    nfa_ram #(
      .WIDTH (nfa_pkg::EDGE_W),
      .DEPTH (NUM_STATES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wr_col == ColW'(k))),
      .waddr_i (wr_row),
      .wdata_i ({in_item.slot_is_char, in_item.slot_char, in_item.slot_target}),
      .raddr_i (raddr),
      .rdata_o (rdata[k])
    );
  end

  // --------------------------------------------------------------------------
  // Row evaluation: the row read in the previous cycle belongs to state
  // cnt_q - 1. Every slot of it is checked in parallel.
  // --------------------------------------------------------------------------
  logic [RowW-1:0]       prow;
  logic [BaseW-1:0]      pbase;
  logic                  row_act;
  logic [NUM_STATES-1:0] row_add;
  logic                  row_new;
  logic                  chg_any;
  logic [NUM_STATES-1:0] step_set;
  logic [NUM_STATES-1:0] start_bit;

  assign prow    = RowW'(cnt_q - CntW'(1));
  assign pbase   = BaseW'(int'(prow) * MAX_TRANS);
  assign row_act = work_q[prow];

  always_comb begin
    logic [BaseW-1:0]           sidx;
    logic                       slot_ok;
    logic                       is_char;
    logic [nfa_pkg::CHAR_W-1:0] ch;
    logic [nfa_pkg::STATE_W-1:0] tgt;
    logic                       hit;
    row_add = '0;
    for (int k = 0; k < MAX_TRANS; k++) begin
      sidx    = pbase + BaseW'(k);
      slot_ok = (int'(sidx) < TblDepth) && vld_q[IdxW'(sidx)];
      is_char = rdata[k][nfa_pkg::EDGE_W-1];
      ch      = rdata[k][nfa_pkg::CHAR_W+nfa_pkg::STATE_W-1:nfa_pkg::STATE_W];
      tgt     = rdata[k][nfa_pkg::STATE_W-1:0];
      if (st_q == nfa_pkg::ST_STEP) begin
        hit = row_live && row_act && slot_ok && is_char && (ch == char_q);
      end else begin
        hit = row_live && row_act && slot_ok && !is_char;
      end
      for (int j = 0; j < NUM_STATES; j++) begin
        if (hit && (int'(tgt) == j)) begin
          row_add[j] = 1'b1;
        end
      end
    end
  end

  assign row_new  = |(row_add & ~work_q);
  assign chg_any  = chg_q || row_new;
  assign step_set = nxt_q | row_add;

  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) begin
      start_bit[j] = (int'(start_q) == j);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      nfa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_item.req_type == nfa_pkg::REQ_EMPTY) begin
            st_d = nfa_pkg::ST_START;
          end else if (in_item.req_type == nfa_pkg::REQ_CHAR) begin
            if (in_item.first) begin
              st_d = nfa_pkg::ST_START;
            end else if (dead_q) begin
              st_d = in_item.last ? nfa_pkg::ST_RESP : nfa_pkg::ST_IDLE;
            end else begin
              st_d = nfa_pkg::ST_STEP;
            end
          end
        end
      end
      nfa_pkg::ST_START: begin
        if (pass_end && !chg_any) begin
          st_d = query_q ? nfa_pkg::ST_RESP : nfa_pkg::ST_STEP;
        end
      end
      nfa_pkg::ST_STEP: begin
        if (pass_end) begin
          if (step_set == '0) begin
            st_d = last_q ? nfa_pkg::ST_RESP : nfa_pkg::ST_IDLE;
          end else begin
            st_d = nfa_pkg::ST_CLOSE;
          end
        end
      end
      nfa_pkg::ST_CLOSE: begin
        if (pass_end && !chg_any) begin
          st_d = last_q ? nfa_pkg::ST_RESP : nfa_pkg::ST_IDLE;
        end
      end
      nfa_pkg::ST_RESP: begin
        if (out_fire) begin
          st_d = nfa_pkg::ST_IDLE;
        end
      end
      default: st_d = nfa_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: handshake outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    case (st_q)
      nfa_pkg::ST_IDLE: in_i.ready  = 1'b1;
      nfa_pkg::ST_RESP: out_o.valid = 1'b1;
      default: begin
        in_i.ready  = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
  end

  assign cfg_i.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Datapath updates.
  // --------------------------------------------------------------------------
  always_comb begin
    work_d   = work_q;
    nxt_d    = nxt_q;
    active_d = active_q;
    dead_d   = dead_q;
    chg_d    = chg_q;
    cnt_d    = cnt_q;
    char_d   = char_q;
    last_d   = last_q;
    query_d  = query_q;
    start_d  = start_q;
    acc_d    = acc_q;
    vld_d    = vld_q;

    if (cfg_fire) begin
      if (cfg_item.addr == nfa_pkg::CFG_START) begin
        start_d = cfg_item.wdata;
      end else begin
        acc_d = cfg_item.wdata;
      end
    end

    if (wr_en) begin
      vld_d[in_item.slot_index[IdxW-1:0]] = in_item.slot_valid;
    end

    if (in_fire && (in_item.req_type == nfa_pkg::REQ_EMPTY)) begin
      work_d  = start_bit;
      query_d = 1'b1;
      cnt_d   = '0;
      chg_d   = 1'b0;
    end

    if (in_fire && (in_item.req_type == nfa_pkg::REQ_CHAR)) begin
      char_d  = in_item.char_value;
      last_d  = in_item.last;
      query_d = 1'b0;
      cnt_d   = '0;
      chg_d   = 1'b0;
      nxt_d   = '0;
      if (in_item.first) begin
        work_d = start_bit;
        dead_d = 1'b0;
      end else begin
        work_d = active_q;
      end
    end

    if (in_pass) begin
      cnt_d = cnt_q + CntW'(1);
      if (st_q == nfa_pkg::ST_STEP) begin
        nxt_d = step_set;
      end else begin
        work_d = work_q | row_add;
        chg_d  = chg_any;
      end
    end

    if (pass_end) begin
      case (st_q)
        nfa_pkg::ST_START: begin
          cnt_d = '0;
          chg_d = 1'b0;
          nxt_d = '0;
        end
        nfa_pkg::ST_STEP: begin
          cnt_d = '0;
          chg_d = 1'b0;
          if (step_set == '0) begin
            dead_d   = 1'b1;
            active_d = '0;
          end else begin
            work_d = step_set;
          end
        end
        nfa_pkg::ST_CLOSE: begin
          cnt_d = '0;
          chg_d = 1'b0;
          if (!chg_any) begin
            active_d = work_q;
          end
        end
        default: cnt_d = '0;
      endcase
    end
  end

  // Result: a query reports its own closure, a string reports the active set.
  logic [NUM_STATES-1:0] res_set;
  logic                  acc_hit;

  assign res_set = query_q ? work_q : active_q;

  always_comb begin
    acc_hit = 1'b0;
    for (int j = 0; j < NUM_STATES; j++) begin
      if (res_set[j] && (int'(acc_q) == j)) begin
        acc_hit = 1'b1;
      end
    end
  end

  assign res.matched    = query_q ? acc_hit : (!dead_q && acc_hit);
  assign res.died_early = !query_q && dead_q;
  assign out_o.data     = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= nfa_pkg::ST_IDLE;
      active_q <= '0;
      dead_q   <= 1'b0;
      chg_q    <= 1'b0;
      cnt_q    <= '0;
      query_q  <= 1'b0;
      last_q   <= 1'b0;
      start_q  <= '0;
      acc_q    <= nfa_pkg::STATE_W'(1);
      vld_q    <= '0;
    end else begin
      st_q     <= st_d;
      active_q <= active_d;
      dead_q   <= dead_d;
      chg_q    <= chg_d;
      cnt_q    <= cnt_d;
      query_q  <= query_d;
      last_q   <= last_d;
      start_q  <= start_d;
      acc_q    <= acc_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    nxt_q  <= nxt_d;
    char_q <= char_d;
  end

endmodule

/* src/nfa_ram.sv */
// ----------------------------------------------------------------------------
// nfa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nfa_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/nfa_checker.sv */
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks of the matcher's handshake behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_data
);

  // The block works on one request at a time, so a pending result blocks input.
  `NFA_ASSERT(a_busy_while_result, clk_i, rst_ni, out_valid |-> !in_ready, "input ready while a result is pending")

  // A table write finishes in its own cycle and leaves the block idle.
  `NFA_ASSERT(a_write_single_cycle, clk_i, rst_ni, (in_valid && in_ready && (in_req == nfa_pkg::REQ_WRITE)) |=> in_ready, "table write did not return to idle")

  // An empty-string query always needs at least one closure pass.
  `NFA_ASSERT(a_query_busy, clk_i, rst_ni, (in_valid && in_ready && (in_req == nfa_pkg::REQ_EMPTY)) |=> (!in_ready && !out_valid), "empty-string query answered without a closure pass")

  // A stalled result transaction keeps its payload.
  `NFA_ASSERT(a_result_holds, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled result changed or dropped")

  // No result is offered while reset is asserted.
  `NFA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid, "result offered during reset")

endmodule

bind nfa_string_matcher nfa_checker u_nfa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_req    (in_i.data.req_type),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NFA whole-string matcher.
// ----------------------------------------------------------------------------
// A short table of hand-written requests comes first, a few of them with
// the result typed in. Then come phases with different start and accept
// states and idle patterns. Each phase loads a small random automaton and
// streams strings whose bytes mostly follow live edges. A mirror of the
// edge table and of the active set predicts every result that is not typed
// in, and the results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_ST   = nfa_pkg::NUM_STATES_DEF;
  localparam int N_TR   = nfa_pkg::MAX_TRANS_DEF;
  localparam int N_SLOT = N_ST * N_TR;
  localparam int N_PHASE = 8;
  localparam int ITEMS_PER_PHASE = 235;
  // Worst byte: closure of the start state, one character pass, one full closure.
  localparam int SETTLE_CYCLES = (2 * N_ST + 6) * (N_ST + 1);

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam nfa_pkg::out_item_t RES_NONE  = '{matched: 1'b0, died_early: 1'b0};
  localparam nfa_pkg::out_item_t RES_MATCH = '{matched: 1'b1, died_early: 1'b0};
  localparam nfa_pkg::out_item_t RES_DEAD  = '{matched: 1'b0, died_early: 1'b1};

  typedef struct packed {
    logic                        ok;
    logic                        is_chr;
    logic [nfa_pkg::CHAR_W-1:0]  sym;
    logic [nfa_pkg::STATE_W-1:0] dst;
  } edge_t;

  typedef struct {
    nfa_pkg::in_item_t  req;
    bit                 typed;
    nfa_pkg::out_item_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  nfa_stream_if #(.T(nfa_pkg::in_item_t))  in_if ();
  nfa_stream_if #(.T(nfa_pkg::out_item_t)) out_if ();
  nfa_stream_if #(.T(nfa_pkg::cfg_item_t)) cfg_if ();

  nfa_string_matcher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Mirror of the block state.
  edge_t                       edge_mem [N_SLOT] = '{default: '0};
  logic [N_ST-1:0]             nfa_active = '0;
  logic                        nfa_dead = 1'b0;
  logic [nfa_pkg::STATE_W-1:0] start_reg = 5'd0;
  logic [nfa_pkg::STATE_W-1:0] accept_reg = 5'd1;

  nfa_pkg::out_item_t pending_results [$];
  dir_row_t           dir_rows [$];
  bit                 typed_pending = 1'b0;
  nfa_pkg::out_item_t typed_res = RES_NONE;
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  logic [nfa_pkg::CHAR_W-1:0] alph [4];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [N_ST-1:0] st_bit(input logic [nfa_pkg::STATE_W-1:0] s);
    logic [N_ST-1:0] b;
    b = '0;
    if (int'(s) < N_ST) b[s] = 1'b1;
    return b;
  endfunction

  // One pass over the rows of all active states: character edges that
  // consume sym, or epsilon edges.
  function automatic logic [N_ST-1:0] follow_edges(input logic [N_ST-1:0] set,
                                                   input bit want_char,
                                                   input logic [nfa_pkg::CHAR_W-1:0] sym);
    logic [N_ST-1:0] nxt;
    edge_t e;
    nxt = '0;
    for (int s = 0; s < N_ST; s++) begin
      if (set[s]) begin
        for (int k = 0; k < N_TR; k++) begin
          e = edge_mem[s * N_TR + k];
          if (e.ok && (want_char ? (e.is_chr && e.sym == sym) : !e.is_chr))
            nxt = nxt | st_bit(e.dst);
        end
      end
    end
    return nxt;
  endfunction

  function automatic logic [N_ST-1:0] eps_close(input logic [N_ST-1:0] set);
    logic [N_ST-1:0] prev;
    do begin
      prev = set;
      set = set | follow_edges(set, 1'b0, '0);
    end while (set != prev);
    return set;
  endfunction

  // Advances the mirror by one accepted request; returns 1 with res filled
  // when the request produces a result.
  function automatic bit apply_req(input nfa_pkg::in_item_t it,
                                   output nfa_pkg::out_item_t res);
    logic [N_ST-1:0] nxt;
    bit got;
    got = 1'b0;
    res = RES_NONE;
    case (it.req_type)
      nfa_pkg::REQ_WRITE: begin
        if (int'(it.slot_index) < N_SLOT)
          edge_mem[it.slot_index] = '{it.slot_valid, it.slot_is_char, it.slot_char,
                                      it.slot_target};
      end
      nfa_pkg::REQ_EMPTY: begin
        res.matched = |(eps_close(st_bit(start_reg)) & st_bit(accept_reg));
        got = 1'b1;
      end
      nfa_pkg::REQ_CHAR: begin
        if (it.first) begin
          nfa_active = eps_close(st_bit(start_reg));
          nfa_dead = 1'b0;
        end
        if (!nfa_dead) begin
          nxt = follow_edges(nfa_active, 1'b1, it.char_value);
          if (nxt == '0) begin
            nfa_dead = 1'b1;
            nfa_active = '0;
          end else begin
            nfa_active = eps_close(nxt);
          end
        end
        if (it.last) begin
          res.matched = !nfa_dead && |(nfa_active & st_bit(accept_reg));
          res.died_early = nfa_dead;
          got = 1'b1;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  // Mostly a byte that some live state can consume, so strings get deep.
  function automatic logic [nfa_pkg::CHAR_W-1:0] pick_sym(input logic [N_ST-1:0] set);
    logic [nfa_pkg::CHAR_W-1:0] cand [$];
    edge_t e;
    for (int s = 0; s < N_ST; s++) begin
      if (set[s]) begin
        for (int k = 0; k < N_TR; k++) begin
          e = edge_mem[s * N_TR + k];
          if (e.ok && e.is_chr) cand.push_back(e.sym);
        end
      end
    end
    if (cand.size() != 0 && $urandom_range(99) < 85)
      return cand[$urandom_range(cand.size() - 1)];
    if ($urandom_range(1) == 1) return alph[$urandom_range(3)];
    return nfa_pkg::CHAR_W'($urandom_range(255));
  endfunction

  function automatic nfa_pkg::in_item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(nfa_pkg::in_item_t)-1:0];
  endfunction

  function automatic nfa_pkg::in_item_t mk_kind(input logic [1:0] kind);
    nfa_pkg::in_item_t it;
    it = rand_item();
    it.req_type = kind;
    return it;
  endfunction

  function automatic nfa_pkg::in_item_t mk_write(input int slot, input bit ok,
                                                 input bit is_chr,
                                                 input logic [nfa_pkg::CHAR_W-1:0] sym,
                                                 input logic [nfa_pkg::STATE_W-1:0] dst);
    nfa_pkg::in_item_t it;
    it = mk_kind(nfa_pkg::REQ_WRITE);
    it.slot_index = nfa_pkg::SLOT_W'(slot);
    it.slot_valid = ok;
    it.slot_is_char = is_chr;
    it.slot_char = sym;
    it.slot_target = dst;
    return it;
  endfunction

  function automatic nfa_pkg::in_item_t mk_byte(input logic [nfa_pkg::CHAR_W-1:0] ch,
                                                input bit first_f, input bit last_f);
    nfa_pkg::in_item_t it;
    it = mk_kind(nfa_pkg::REQ_CHAR);
    it.char_value = ch;
    it.first = first_f;
    it.last = last_f;
    return it;
  endfunction

  task automatic dir_add(input nfa_pkg::in_item_t req, input bit typed,
                         input nfa_pkg::out_item_t res);
    dir_row_t row;
    row.req = req;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the
  // transaction, with valid still high so back-to-back items need no toggle.
  task automatic send_req(input nfa_pkg::in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data = it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [nfa_pkg::STATE_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.data = '{addr: idx, wdata: val};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_if.ready = !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    nfa_pkg::out_item_t res;
    nfa_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: matched=%0b died_early=%0b",
                     out_if.data.matched, out_if.data.died_early);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.data.matched !== want.matched ||
              out_if.data.died_early !== want.died_early) begin
            if (mismatches < 10)
              $display("result mismatch: expected matched=%0b died_early=%0b, got %0b %0b",
                       want.matched, want.died_early, out_if.data.matched,
                       out_if.data.died_early);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.addr)
          nfa_pkg::CFG_START:  start_reg = cfg_if.data.wdata;
          nfa_pkg::CFG_ACCEPT: accept_reg = cfg_if.data.wdata;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        if (apply_req(in_if.data, res)) begin
          if (typed_pending) res = typed_res;
          pending_results.push_back(res);
        end
      end
    end
  end

  initial begin
    int cnt;
    int k_used;
    int len;
    bit use_first;
    bit close_str;
    int roll;
    logic [nfa_pkg::STATE_W-1:0] s_new;
    logic [nfa_pkg::STATE_W-1:0] a_new;
    logic [nfa_pkg::STATE_W-1:0] used [8];
    logic [N_ST-1:0] live;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b1;
    foreach (alph[i]) alph[i] = 8'h61 + nfa_pkg::CHAR_W'(i);

    // Directed rows run with the reset values: start 0, accept 1.
    dir_add(mk_kind(nfa_pkg::REQ_EMPTY), 1'b1, RES_NONE);
    dir_add(mk_byte(8'h61, 1'b0, 1'b1), 1'b1, RES_DEAD);  // no first after reset
    dir_add(mk_kind(REQ_UNUSED), 1'b0, RES_NONE);
    dir_add(mk_write(0, 1'b1, 1'b1, 8'h61, 5'd1), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h61, 1'b1, 1'b1), 1'b1, RES_MATCH);
    dir_add(mk_write(4, 1'b1, 1'b0, 8'h00, 5'd2), 1'b0, RES_NONE);
    dir_add(mk_write(8, 1'b1, 1'b1, 8'hFF, 5'd1), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h61, 1'b1, 1'b0), 1'b0, RES_NONE);
    dir_add(mk_kind(nfa_pkg::REQ_EMPTY), 1'b0, RES_NONE);  // must leave the string alone
    dir_add(mk_byte(8'hFF, 1'b0, 1'b0), 1'b0, RES_NONE);
    dir_add(mk_byte(8'hFF, 1'b0, 1'b1), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h00, 1'b1, 1'b1), 1'b1, RES_DEAD);  // dies on its last byte
    dir_add(mk_byte(8'h00, 1'b1, 1'b0), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h61, 1'b0, 1'b0), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h61, 1'b0, 1'b1), 1'b1, RES_DEAD);
    dir_add(mk_write(N_SLOT - 1, 1'b1, 1'b1, 8'hFF, 5'd31), 1'b0, RES_NONE);
    dir_add(mk_write(1, 1'b1, 1'b0, 8'hFF, 5'd1), 1'b0, RES_NONE);
    dir_add(mk_kind(nfa_pkg::REQ_EMPTY), 1'b0, RES_NONE);
    dir_add(mk_write(1, 1'b0, 1'b1, 8'hFF, 5'd31), 1'b0, RES_NONE);
    dir_add(mk_kind(nfa_pkg::REQ_EMPTY), 1'b0, RES_NONE);
    dir_add(mk_write(2, 1'b1, 1'b1, 8'h00, 5'd31), 1'b0, RES_NONE);
    dir_add(mk_byte(8'h00, 1'b1, 1'b0), 1'b0, RES_NONE);
    dir_add(mk_byte(8'hFF, 1'b0, 1'b1), 1'b0, RES_NONE);  // alive, not accepting

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      typed_pending = dir_rows[i].typed;
      typed_res = dir_rows[i].res;
      send_req(dir_rows[i].req);
    end
    typed_pending = 1'b0;

    for (int ph = 0; ph < N_PHASE; ph++) begin
      // Registers change only on an idle block.
      in_if.valid = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk_i);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase

      case (ph)
        0: begin s_new = 5'd0;  a_new = 5'd31; end
        1: begin s_new = 5'd31; a_new = 5'd0;  end
        2: begin s_new = 5'd17; a_new = 5'd17; end
        default: begin
          s_new = nfa_pkg::STATE_W'($urandom_range(N_ST - 1));
          a_new = nfa_pkg::STATE_W'($urandom_range(N_ST - 1));
        end
      endcase
      cfg_write(nfa_pkg::CFG_START, s_new);
      cfg_write(nfa_pkg::CFG_ACCEPT, a_new);
      cfg_if.valid = 1'b0;

      // A small automaton over a few states and a four-byte alphabet keeps
      // epsilon chains short and matches frequent.
      cnt = 0;
      k_used = $urandom_range(3, 8);
      used[0] = s_new;
      used[1] = a_new;
      for (int u = 2; u < 8; u++) used[u] = nfa_pkg::STATE_W'($urandom_range(N_ST - 1));
      alph[0] = ph[0] ? 8'hFF : 8'h00;
      for (int i = 1; i < 4; i++) alph[i] = nfa_pkg::CHAR_W'($urandom_range(255));
      for (int u = 0; u < k_used; u++) begin
        for (int k = 0; k < N_TR; k++) begin
          send_req(mk_write(int'(used[u]) * N_TR + k, $urandom_range(99) < 75,
                            $urandom_range(99) < 70, alph[$urandom_range(3)],
                            used[$urandom_range(k_used - 1)]));
          cnt++;
        end
      end

      while (cnt < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_req(mk_kind(nfa_pkg::REQ_EMPTY));
          cnt++;
        end else if (roll < 10) begin
          send_req(mk_kind(nfa_pkg::REQ_WRITE));
          cnt++;
        end else if (roll < 13) begin
          send_req(mk_kind(REQ_UNUSED));
        end else if (roll == 13) begin
          in_if.valid = 1'b0;
          wait_drained();
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
          use_first = $urandom_range(99) < 93;
          close_str = $urandom_range(99) < 95;
          for (int i = 0; i < len; i++) begin
            // The mirror is current here: the previous byte was taken.
            live = (i == 0 && use_first) ? eps_close(st_bit(start_reg)) : nfa_active;
            send_req(mk_byte(pick_sym(live), i == 0 && use_first,
                             i == len - 1 && close_str));
            cnt++;
          end
        end
      end
    end

    in_if.valid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
